FILE: rtl/core/knps_pkg.sv
package knps_pkg;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_QUERY  = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_ACCUM,
      ST_INSERT,
      ST_WRITE,
      ST_EMIT
   } state_type;

   localparam int unsigned COORD_W = 16;
   localparam int unsigned SQ_W    = 33;
   localparam int unsigned DIST_W  = 36;
   localparam int unsigned IDX_W   = 10;
   localparam int unsigned OUTD_W  = 35;

   localparam logic [3:0] REG_DIMENSIONS = 4'd0;
   localparam logic [3:0] REG_NEIGHBORS  = 4'd1;

   localparam logic [DIST_W-1:0] DIST_INIT = '1;

endpackage

FILE: rtl/core/knps_ram.sv
module knps_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/core/k_nearest_point_search.sv
// Sequence: append goes through ST_WRITE to ST_EMIT; query first scans every stored point
// (ST_READ, ST_ACCUM, ST_INSERT), then goes through ST_WRITE to ST_EMIT and its responses.
// Throughput: one request at a time, taken only after its last response is accepted;
// the scan handles each coordinate in ST_READ then ST_ACCUM, so the scan length sets the rate.
// Reset: synchronous, active high; empties the store, sets both registers
// to 3. The coordinate memory is not cleared.
module k_nearest_point_search
   import knps_pkg::*;
#(
   parameter int unsigned MAX_POINTS    = 1024,
   parameter int unsigned MAX_NEIGHBORS = 8,
   parameter int unsigned MAX_DIMS      = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_command,
   input  logic signed [15:0]  req_coord_0,
   input  logic signed [15:0]  req_coord_1,
   input  logic signed [15:0]  req_coord_2,
   input  logic signed [15:0]  req_coord_3,
   input  logic signed [15:0]  req_coord_4,
   input  logic signed [15:0]  req_coord_5,
   input  logic signed [15:0]  req_coord_6,
   input  logic signed [15:0]  req_coord_7,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [IDX_W-1:0]    rsp_neighbor_index,
   output logic [OUTD_W-1:0]   rsp_distance_sq,
   output logic [2:0]          rsp_rank,
   output logic                rsp_neighbor_valid,
   output logic [IDX_W-1:0]    rsp_new_index,
   output logic                rsp_store_full,
   output logic                rsp_last,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [3:0]          csr_index,
   input  logic [3:0]          csr_data
);

   localparam int unsigned PW    = $clog2(MAX_POINTS);
   localparam int unsigned CW    = $clog2(MAX_POINTS + 1);
   localparam int unsigned DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int unsigned NW    = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
   localparam int unsigned KW    = $clog2(MAX_NEIGHBORS + 1);
   localparam int unsigned AW    = $clog2(MAX_POINTS * MAX_DIMS);
   localparam int unsigned DEPTH = MAX_POINTS * MAX_DIMS;

   state_type state_ff, state_in;

   logic [3:0]              dims_reg_ff, nbr_reg_ff;
   logic [CW-1:0]           total_ff, total_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [COORD_W-1:0]      q_ff [MAX_DIMS];
   logic [CW-1:0]           p_ff, p_in;
   logic [DW-1:0]           d_ff, d_in;
   logic [DIST_W-1:0]       acc_ff, acc_in;
   logic [DIST_W-1:0]       bd_ff [MAX_NEIGHBORS];
   logic [PW-1:0]           bi_ff [MAX_NEIGHBORS];
   logic [NW-1:0]           r_ff, r_in;
   logic [KW-1:0]           filled_ff, filled_in;
   logic [PW-1:0]           slot_ff, slot_in;
   logic                    full_ff, full_in;
   logic                    clr_best, ins_en;

   logic                    wr_en;
   logic [AW-1:0]           wr_addr, rd_addr;
   logic [COORD_W-1:0]      wr_data, rd_data;

   logic [DW:0]             dims_eff;
   logic [KW-1:0]           k_eff;
   logic [COORD_W-1:0]      req_coord [8];

   logic signed [COORD_W:0] diff;
   logic [SQ_W-1:0]         sq;
   logic [DIST_W-1:0]       cand_dist;
   logic [MAX_NEIGHBORS-1:0] less;

   assign req_coord[0] = req_coord_0;
   assign req_coord[1] = req_coord_1;
   assign req_coord[2] = req_coord_2;
   assign req_coord[3] = req_coord_3;
   assign req_coord[4] = req_coord_4;
   assign req_coord[5] = req_coord_5;
   assign req_coord[6] = req_coord_6;
   assign req_coord[7] = req_coord_7;

   always_comb begin
      if (dims_reg_ff == 4'd0) begin
         dims_eff = (DW+1)'(1);
      end else if (32'(dims_reg_ff) > MAX_DIMS) begin
         dims_eff = (DW+1)'(MAX_DIMS);
      end else begin
         dims_eff = (DW+1)'(dims_reg_ff);
      end
      if (nbr_reg_ff == 4'd0) begin
         k_eff = KW'(1);
      end else if (32'(nbr_reg_ff) > MAX_NEIGHBORS) begin
         k_eff = KW'(MAX_NEIGHBORS);
      end else begin
         k_eff = KW'(nbr_reg_ff);
      end
   end

   knps_ram #(.WIDTH(COORD_W), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // squared difference of the coordinate read in the previous cycle
   always_comb begin
      diff = $signed({q_ff[d_ff][COORD_W-1], q_ff[d_ff]})
           - $signed({rd_data[COORD_W-1], rd_data});
      sq   = SQ_W'($unsigned(34'(diff) * 34'(diff)));
   end

   assign cand_dist = acc_ff;

   always_comb begin
      for (int j = 0; j < MAX_NEIGHBORS; j++) begin
         less[j] = (j < k_eff) && (cand_dist < bd_ff[j]);
      end
   end

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_reg_ff <= 4'd3;
         nbr_reg_ff  <= 4'd3;
      end else if (csr_valid) begin
         if (csr_index == REG_DIMENSIONS) begin
            dims_reg_ff <= csr_data;
         end else if (csr_index == REG_NEIGHBORS) begin
            nbr_reg_ff <= csr_data;
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      total_in  = total_ff;
      cmd_in    = cmd_ff;
      p_in      = p_ff;
      d_in      = d_ff;
      acc_in    = acc_ff;
      r_in      = r_ff;
      filled_in = filled_ff;
      slot_in   = slot_ff;
      full_in   = full_ff;
      clr_best  = 1'b0;
      ins_en    = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = AW'(32'(p_ff[PW-1:0]) * MAX_DIMS + 32'(d_ff));
      wr_data   = q_ff[d_ff];
      rd_addr   = wr_addr;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd_in = cmd_type'(req_command);
               p_in   = '0;
               d_in   = '0;
               acc_in = '0;
               r_in   = '0;
               clr_best = 1'b1;
               unique case (cmd_type'(req_command))
                  CMD_APPEND: state_in = ST_WRITE;
                  CMD_QUERY:  state_in = (total_ff == '0) ? ST_WRITE : ST_READ;
                  CMD_CLEAR:  total_in = '0;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            acc_in = acc_ff + DIST_W'(sq);
            if (32'(d_ff) + 1 >= 32'(dims_eff)) begin
               state_in = ST_INSERT;
               d_in     = '0;
            end else begin
               d_in     = d_ff + DW'(1);
               state_in = ST_READ;
            end
         end
         ST_INSERT: begin
            ins_en = 1'b1;
            acc_in = '0;
            p_in   = p_ff + CW'(1);
            state_in = (p_ff + CW'(1) >= total_ff) ? ST_WRITE : ST_READ;
            if (state_in == ST_WRITE) begin
               p_in = '0;
            end
         end
         ST_WRITE: begin
            if (p_ff == '0) begin
               filled_in = (32'(total_ff) < 32'(k_eff)) ? KW'(total_ff) : k_eff;
               full_in   = (32'(total_ff) >= MAX_POINTS);
               slot_in   = full_in ? '0 : total_ff[PW-1:0];
            end
            wr_en   = !full_in;
            wr_addr = AW'(32'(slot_in) * MAX_DIMS + 32'(d_ff));
            if (32'(d_ff) + 1 >= MAX_DIMS) begin
               d_in     = '0;
               state_in = ST_EMIT;
               if (!full_in) begin
                  total_in = total_ff + CW'(1);
               end
            end else begin
               d_in = d_ff + DW'(1);
               p_in = CW'(1);
            end
         end
         ST_EMIT: begin
            if (!rsp_valid || rsp_ready) begin
               if (cmd_ff == CMD_APPEND || filled_ff == '0
                   || 32'(r_ff) + 1 >= 32'(filled_ff)) begin
                  state_in = ST_IDLE;
               end else begin
                  r_in = r_ff + NW'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      p_ff      <= p_in;
      d_ff      <= d_in;
      acc_ff    <= acc_in;
      r_ff      <= r_in;
      filled_ff <= filled_in;
      slot_ff   <= slot_in;
      full_ff   <= full_in;
      if (state_ff == ST_IDLE && req_valid && req_ready) begin
         for (int d = 0; d < MAX_DIMS; d++) begin
            q_ff[d] <= req_coord[d];
         end
      end
   end

   // hold the sorted list; insert at the first larger entry, shifting it and those below down
   always_ff @(posedge clock) begin
      if (clr_best) begin
         for (int j = 0; j < MAX_NEIGHBORS; j++) begin
            bd_ff[j] <= DIST_INIT;
         end
      end else if (ins_en) begin
         for (int j = 0; j < MAX_NEIGHBORS; j++) begin
            if (less[j]) begin
               if (j == 0 || !less[(j > 0) ? j - 1 : 0]) begin
                  bd_ff[j] <= cand_dist;
                  bi_ff[j] <= p_ff[PW-1:0];
               end else begin
                  bd_ff[j] <= bd_ff[(j > 0) ? j - 1 : 0];
                  bi_ff[j] <= bi_ff[(j > 0) ? j - 1 : 0];
               end
            end
         end
      end
   end

   logic emit_fire;
   assign emit_fire = (state_ff == ST_EMIT) && (!rsp_valid || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (emit_fire) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_new_index  <= IDX_W'(slot_ff);
         rsp_store_full <= full_ff;
         if (cmd_ff == CMD_APPEND || filled_ff == '0) begin
            rsp_neighbor_index <= '0;
            rsp_distance_sq    <= '0;
            rsp_rank           <= '0;
            rsp_neighbor_valid <= 1'b0;
            rsp_last           <= 1'b1;
         end else begin
            rsp_neighbor_index <= IDX_W'(bi_ff[r_ff]);
            rsp_distance_sq    <= bd_ff[r_ff][OUTD_W-1:0];
            rsp_rank           <= 3'(r_ff);
            rsp_neighbor_valid <= 1'b1;
            rsp_last           <= (32'(r_ff) + 1 >= 32'(filled_ff));
         end
      end
   end

endmodule

FILE: rtl/core/knps_checker.sv
module knps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_neighbor_valid,
   input logic        rsp_last,
   input logic [2:0]  rsp_rank,
   input logic [34:0] rsp_distance_sq
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rank))
      else $error("response dropped while stalled");

   a_invalid_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_neighbor_valid |-> rsp_last && rsp_rank == 3'd0)
      else $error("invalid response not single");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken during response");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_neighbor_valid |-> rsp_distance_sq == '0)
      else $error("invalid response carries distance");

endmodule

bind k_nearest_point_search knps_checker u_knps_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_neighbor_valid (rsp_neighbor_valid),
   .rsp_last           (rsp_last),
   .rsp_rank           (rsp_rank),
   .rsp_distance_sq    (rsp_distance_sq)
);
